[hdl/sdf_pkg.sv]
// ----------------------------------------------------------------------------
// sdf_pkg: shared types and constants of the signed decimal formatter
// Input and output item structs, the job descriptor passed from the front
// to the back, ASCII codes and sizing constants.
// ----------------------------------------------------------------------------
package sdf_pkg;

  // Default limits, handed down from the top level
  localparam int MAX_WIDTH_DEF     = 63;
  localparam int MAX_PRECISION_DEF = 40;

  // BCD digits needed for a 64 bit magnitude
  localparam int NUM_BCD   = 20;
  localparam int DIGIT_W   = $clog2(NUM_BCD);
  // Character positions and lengths (at most 64 characters)
  localparam int CNT_W     = 7;
  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    SIZE_8  = 2'd0,
    SIZE_16 = 2'd1,
    SIZE_32 = 2'd2,
    SIZE_64 = 2'd3
  } size_mode_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         size_mode;
    logic [5:0]         field_width;
    logic [5:0]         min_digits;
    logic               left_justify;
    logic               zero_pad;
    logic               force_plus;
    logic               space_sign;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_t;

  // Classified item: magnitude left aligned to bit 63
  typedef struct packed {
    logic [63:0] mag;
    logic [1:0]  size_mode;
    logic        has_sign;
    logic [7:0]  sign_ch;
    logic [5:0]  prec;
    logic [5:0]  width;
    logic        left;
    logic        zmode;
  } job_t;

endpackage

[hdl/sdf_front.sv]
// ----------------------------------------------------------------------------
// sdf_front: item classifier
// Sign-extends the value to its size mode, forms the unsigned magnitude,
// picks the sign character and clamps width and precision.
// ----------------------------------------------------------------------------
module sdf_front #(
  parameter int MAX_WIDTH     = sdf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_PRECISION = sdf_pkg::MAX_PRECISION_DEF
) (
  input  sdf_pkg::in_t  item,
  output sdf_pkg::job_t job
);
  import sdf_pkg::*;

  localparam logic [6:0] MaxWidthL = 7'(MAX_WIDTH);
  localparam logic [5:0] MaxPrecL  = 6'(MAX_PRECISION);

  logic [63:0] sext;
  logic [63:0] mag;
  logic        neg;

  always_comb begin
    unique case (size_mode_t'(item.size_mode))
      SIZE_8:  sext = {{56{item.value[7]}},  item.value[7:0]};
      SIZE_16: sext = {{48{item.value[15]}}, item.value[15:0]};
      SIZE_32: sext = {{32{item.value[31]}}, item.value[31:0]};
      SIZE_64: sext = item.value;
      default: sext = item.value;
    endcase
  end

  assign neg = sext[63];
  // most negative value wraps to its exact unsigned magnitude
  assign mag = neg ? (64'd0 - sext) : sext;

  always_comb begin
    job = '0;
    unique case (size_mode_t'(item.size_mode))
      SIZE_8:  job.mag = {mag[7:0],  56'd0};
      SIZE_16: job.mag = {mag[15:0], 48'd0};
      SIZE_32: job.mag = {mag[31:0], 32'd0};
      SIZE_64: job.mag = mag;
      default: job.mag = mag;
    endcase
    job.size_mode = item.size_mode;
    job.has_sign  = neg | item.force_plus | item.space_sign;
    priority if (neg)             job.sign_ch = CHAR_MINUS;
    else if (item.force_plus)     job.sign_ch = CHAR_PLUS;
    else                          job.sign_ch = CHAR_SPACE;
    job.prec  = (item.min_digits > MaxPrecL) ? MaxPrecL : item.min_digits;
    job.width = ({1'b0, item.field_width} > MaxWidthL) ? MaxWidthL[5:0]
                                                        : item.field_width;
    job.left  = item.left_justify;
    job.zmode = !item.left_justify && item.zero_pad && (item.min_digits == 6'd0);
  end

endmodule

[hdl/sdf_queue.sv]
// ----------------------------------------------------------------------------
// sdf_queue: job queue
// Short register FIFO between the classifier and the formatting engine.
// ----------------------------------------------------------------------------
module sdf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          full,
  input  sdf_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop,
  output sdf_pkg::job_t pop_data
);
  import sdf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  job_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;
  logic              push;
  logic              take;

  assign full      = (count == CNT_QW'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];
  assign push      = push_valid && !full;
  assign take      = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/sdf_back.sv]
// ----------------------------------------------------------------------------
// sdf_back: formatting engine
// Double-dabble conversion one bit per cycle, sizing steps (size, pad, bound),
// then one character per cycle while not stalled, through a registered output.
// ----------------------------------------------------------------------------
module sdf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  sdf_pkg::job_t job_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output sdf_pkg::out_t out_item
);
  import sdf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_PAD,
    ST_BOUND,
    ST_EMIT
  } state_t;

  state_t                     state;
  job_t                       job;
  logic [63:0]                mag;
  logic [NUM_BCD-1:0][3:0]    bcd;
  logic [NUM_BCD-1:0][3:0]    bcd_adj;
  logic [NUM_BCD*4:0]         bcd_shift;
  logic [5:0]                 iter;
  logic [DIGIT_W-1:0]         nd;
  logic [DIGIT_W-1:0]         nd_c;
  logic [DIGIT_W-1:0]         didx;
  logic [CNT_W-1:0]           ndig;
  logic [CNT_W-1:0]           body;
  logic [CNT_W-1:0]           total;
  logic [CNT_W-1:0]           pad;
  logic [CNT_W-1:0]           body_c;
  logic [CNT_W-1:0]           lead_c;
  logic [CNT_W-1:0]           b_sign;
  logic [CNT_W-1:0]           b_zero;
  logic [CNT_W-1:0]           b_dig;
  logic [CNT_W-1:0]           b_end;
  logic [CNT_W-1:0]           last_pos;
  logic [CNT_W-1:0]           pos;
  logic                       emit;
  logic                       emit_dig;
  logic [3:0]                 dig;
  out_t                       out_next;

  // add-3 correction on every BCD digit before the shift
  always_comb begin
    for (int i = 0; i < NUM_BCD; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  // corrected digits shifted up by one, next magnitude bit in at the bottom
  assign bcd_shift = {bcd_adj, mag[63]};

  // significant digit count, at least one
  always_comb begin
    nd_c = DIGIT_W'(1);
    for (int i = 0; i < NUM_BCD; i++) begin
      if (bcd[i] != 4'd0) nd_c = DIGIT_W'(i + 1);
    end
  end

  assign body_c = ndig + {{(CNT_W-1){1'b0}}, job.has_sign};
  assign lead_c = (job.left || job.zmode) ? '0 : pad;

  assign emit = (state == ST_EMIT) && (!out_valid || !out_stall);
  assign dig  = bcd[didx];

  always_comb begin
    emit_dig = 1'b0;
    out_next.last_char = (pos == last_pos);
    priority if (pos < b_sign)  out_next.out_char = CHAR_SPACE;
    else if (pos < b_zero)      out_next.out_char = job.sign_ch;
    else if (pos < b_dig)       out_next.out_char = CHAR_ZERO;
    else if (pos < b_end) begin
      out_next.out_char = CHAR_ZERO + {4'd0, dig};
      emit_dig = emit;
    end else                    out_next.out_char = CHAR_SPACE;
  end

  assign pop = (state == ST_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            job   <= job_data;
            mag   <= job_data.mag;
            bcd   <= '0;
            iter  <= 6'((7'd8 << job_data.size_mode) - 7'd1);
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd  <= bcd_shift[NUM_BCD*4-1:0];
          mag  <= {mag[62:0], 1'b0};
          iter <= iter - 6'd1;
          if (iter == 6'd0) state <= ST_SIZE;
        end
        ST_SIZE: begin
          nd    <= nd_c;
          ndig  <= ({2'b0, nd_c} > {1'b0, job.prec}) ? {2'b0, nd_c} : {1'b0, job.prec};
          state <= ST_PAD;
        end
        ST_PAD: begin
          body  <= body_c;
          total <= ({1'b0, job.width} > body_c) ? {1'b0, job.width} : body_c;
          pad   <= ({1'b0, job.width} > body_c) ? {1'b0, job.width} - body_c : '0;
          state <= ST_BOUND;
        end
        ST_BOUND: begin
          b_sign   <= lead_c;
          b_zero   <= lead_c + {{(CNT_W-1){1'b0}}, job.has_sign};
          b_dig    <= (job.left ? body : total) - {2'b0, nd};
          b_end    <= job.left ? body : total;
          last_pos <= total - 1'b1;
          didx     <= nd - 1'b1;
          pos      <= '0;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit) begin
            out_item <= out_next;
            pos      <= pos + 1'b1;
            if (emit_dig) didx <= didx - 1'b1;
            if (out_next.last_char) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_nd_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BOUND) |-> (nd != '0 && nd <= DIGIT_W'(NUM_BCD)))
    else $error("digit count out of range");

  a_bcd_digit: assert property (@(posedge clk) disable iff (rst)
    emit_dig |-> (didx < DIGIT_W'(NUM_BCD) && dig <= 4'd9))
    else $error("bad BCD digit emitted");

  a_lead_digit: assert property (@(posedge clk) disable iff (rst)
    (emit_dig && didx == nd - 1'b1 && nd != DIGIT_W'(1)) |-> (dig != 4'd0))
    else $error("leading digit is zero");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && out_next.last_char) |=> (state == ST_IDLE))
    else $error("engine busy after last character");

endmodule

[hdl/signed_decimal_formatter.sv]
// ----------------------------------------------------------------------------
// signed_decimal_formatter: printf-style signed decimal conversion
// Formats one signed integer per item into ASCII characters, one per
// output transfer, with the final character of each number marked.
// ----------------------------------------------------------------------------
// Each input transfer carries a value, a size mode (8/16/32/64 bit, the
// value is truncated and sign-extended first) and printf options: field
// width, precision (minimum digits), left-justify, zero-pad, plus and space.
// The sign always precedes zero padding, plus/space also apply to zero, and
// zero-pad is ignored with left-justify or a nonzero precision. Precision is
// clamped to MAX_PRECISION, width to MAX_WIDTH. An item is loaded, then
// converted one double-dabble bit step per cycle over the 8/16/32/64 bits
// of its size mode, then sized, padded and bounded, and then emitted one
// character per cycle while the output is not stalled (max of width and
// sign plus digits) through the output register. A two-entry job queue
// sits between the classifier and the engine, so input transfers keep
// being taken while a number is still being emitted.
// ----------------------------------------------------------------------------
module signed_decimal_formatter #(
  parameter int MAX_WIDTH     = sdf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_PRECISION = sdf_pkg::MAX_PRECISION_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  sdf_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_stall,
  output sdf_pkg::out_t out_item
);
  import sdf_pkg::*;

  job_t front_job;   // classified item from the front
  job_t q_job;       // head of the job queue
  logic q_full;
  logic q_valid;
  logic q_pop;

  // front: sign extension, magnitude, sign char, option clamping
  sdf_front #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_PRECISION (MAX_PRECISION)
  ) u_front (
    .item (in_item),
    .job  (front_job)
  );

  // input transfers stall only when the queue is full
  assign in_stall = q_full;

  sdf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .full       (q_full),
    .push_data  (front_job),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_job)
  );

  // back: BCD conversion, layout and per-character output
  sdf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_data  (q_job),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[tb/sv/signed_decimal_formatter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_decimal_formatter_tb: self-checking bench for the decimal formatter
// Sends directed and random numbers with mixed printf options, predicts the
// character stream of each one, and checks every output transfer in order.
// The sender idles in bursts and the receiver stalls in phases.
// ----------------------------------------------------------------------------
module signed_decimal_formatter_tb;
  import sdf_pkg::*;

  localparam int PREC_LIMIT   = MAX_PRECISION_DEF;
  localparam int WIDTH_LIMIT  = MAX_WIDTH_DEF;
  localparam int RANDOM_COUNT = 310;
  localparam int HOLDOFF_AT   = 60;     // transfers in before the long output hold
  localparam int HOLDOFF_LEN  = 500;    // cycles the receiver holds off
  localparam int DRAIN_AT     = 200;    // sender pauses here until all chars are out
  localparam int TAIL_CYCLES  = 400;    // idle wait for stray output at the end
  localparam int CYCLE_LIMIT  = 1000000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_item = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_item;

  in_t   pending_numbers[$];   // numbers not yet offered to the block
  out_t  expected_chars[$];    // predicted characters, oldest first
  int    numbers_sent = 0;
  int    mismatches = 0;
  int    cycle_count = 0;

  // sender burst state
  int    burst_left = 0;
  int    gap_left = 0;
  // receiver stall state
  int    stall_pct = 0;
  int    phase_left = 0;
  int    holdoff_left = 0;
  bit    holdoff_done = 1'b0;

  signed_decimal_formatter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // --------------------------------------------------------------------------
  // Predictor: text of one formatted number, pushed as expected characters.
  // --------------------------------------------------------------------------
  function automatic void format_decimal(in_t it);
    logic [63:0] v;
    logic [63:0] mag;
    logic [7:0]  digs[20];
    logic [7:0]  txt[$];
    logic [7:0]  sign_ch;
    bit          has_sign;
    bit          zero_fill;
    int          nd, prec, width, ndig, body, pad;
    out_t        r;

    // truncate to the operand size, then sign-extend
    v = it.value;
    case (size_mode_t'(it.size_mode))
      SIZE_8:  v = {{56{v[7]}}, v[7:0]};
      SIZE_16: v = {{48{v[15]}}, v[15:0]};
      SIZE_32: v = {{32{v[31]}}, v[31:0]};
      default: ;
    endcase
    // unsigned negate keeps the most negative value exact
    mag = v[63] ? -v : v;

    // digits, least significant first; zero still gives one digit
    nd = 0;
    do begin
      digs[nd] = CHAR_ZERO + 8'(mag % 64'd10);
      nd++;
      mag = mag / 64'd10;
    end while (mag != 0);

    prec  = (it.min_digits > PREC_LIMIT) ? PREC_LIMIT : int'(it.min_digits);
    width = (it.field_width > WIDTH_LIMIT) ? WIDTH_LIMIT : int'(it.field_width);
    ndig  = (nd > prec) ? nd : prec;

    has_sign = 1'b1;
    if (v[63])                sign_ch = CHAR_MINUS;
    else if (it.force_plus)   sign_ch = CHAR_PLUS;
    else if (it.space_sign)   sign_ch = CHAR_SPACE;
    else begin
      has_sign = 1'b0;
      sign_ch  = CHAR_SPACE;
    end

    body = ndig + (has_sign ? 1 : 0);
    pad  = (width > body) ? width - body : 0;
    // zero padding only right-justified and without a precision
    zero_fill = !it.left_justify && it.zero_pad && (prec == 0);

    if (!it.left_justify && !zero_fill) repeat (pad) txt.push_back(CHAR_SPACE);
    if (has_sign) txt.push_back(sign_ch);
    if (zero_fill) repeat (pad) txt.push_back(CHAR_ZERO);
    repeat (ndig - nd) txt.push_back(CHAR_ZERO);
    for (int i = nd - 1; i >= 0; i--) txt.push_back(digs[i]);
    if (it.left_justify) repeat (pad) txt.push_back(CHAR_SPACE);

    foreach (txt[i]) begin
      r.out_char  = txt[i];
      r.last_char = (i == txt.size() - 1);
      expected_chars.push_back(r);
    end
  endfunction

  function automatic in_t make_number(logic [63:0] value, size_mode_t mode,
                                      int width, int prec, bit left, bit zpad,
                                      bit plus, bit space);
    in_t it;
    it.value        = value;
    it.size_mode    = mode;
    it.field_width  = 6'(width);
    it.min_digits   = 6'(prec);
    it.left_justify = left;
    it.zero_pad     = zpad;
    it.force_plus   = plus;
    it.space_sign   = space;
    return it;
  endfunction

  // Random number: mixes full-range bit patterns, small values, decimal
  // boundaries (10^k and 10^k - 1) and the edges of the chosen size.
  function automatic in_t random_number();
    in_t         it;
    size_mode_t  mode;
    int          bits;
    logic [63:0] v;
    logic [63:0] p;
    mode = size_mode_t'($urandom_range(3));
    bits = 8 << mode;
    case ($urandom_range(5))
      0, 1: v = {$urandom, $urandom};
      2: begin
        v = 64'($urandom_range(1000));
        if ($urandom_range(1)) v = -v;
      end
      3: begin
        p = 64'd1;
        repeat ($urandom_range(19)) p = p * 64'd10;
        v = p - 64'($urandom_range(1));
        if ($urandom_range(1)) v = -v;
      end
      4: begin
        case ($urandom_range(3))
          0: v = (64'd1 << (bits - 1)) - 64'd1;
          1: v = -(64'd1 << (bits - 1));
          2: v = '0;
          default: v = '1;
        endcase
        // junk above the operand size must be dropped
        if (bits < 64 && $urandom_range(1)) v = v ^ ({$urandom, $urandom} << bits);
      end
      default: v = 64'($urandom);
    endcase
    it = make_number(v, mode, 0, 0, $urandom_range(1), $urandom_range(1),
                     $urandom_range(1), $urandom_range(1));
    // mostly short fields, now and then up to the 6 bit limit
    it.field_width = ($urandom_range(4) == 0) ? 6'($urandom_range(63))
                                              : 6'($urandom_range(24));
    case ($urandom_range(5))
      0, 1, 2: it.min_digits = '0;
      3:       it.min_digits = 6'($urandom_range(63));  // includes clamped values
      default: it.min_digits = 6'($urandom_range(25));
    endcase
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers numbers from the queue in bursts; payload holds while
  // stalled. Each accepted transfer is handed to the predictor.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        format_decimal(in_item);
        numbers_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_numbers.size() == 0 ||
                     (numbers_sent == DRAIN_AT && expected_chars.size() != 0)) begin
          // out of work, or waiting for the block to empty completely
          in_valid <= 1'b0;
        end else begin
          in_item  <= pending_numbers.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(30);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall rate changes phase by phase (none, light, half, heavy).
  // Once, a long hold fills the block so that it stalls its own input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else if (!holdoff_done && numbers_sent >= HOLDOFF_AT) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_LEN;
      out_stall <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        case ($urandom_range(3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
        phase_left = $urandom_range(10, 200);
      end else begin
        phase_left--;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: each output transfer against the oldest expected character.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_chars
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected char: got %h (%c) last=%b", $realtime,
                   out_item.out_char, out_item.out_char, out_item.last_char);
      end else begin
        want = expected_chars.pop_front();
        if (out_item.out_char !== want.out_char ||
            out_item.last_char !== want.last_char) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] char mismatch: exp %h (%c) last=%b, got %h (%c) last=%b",
                     $realtime, want.out_char, want.out_char, want.last_char,
                     out_item.out_char, out_item.out_char, out_item.last_char);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : run
    bit timed_out;

    // zero and its sign options, precision on zero
    pending_numbers.push_back(make_number(64'd0, SIZE_64, 0, 0, 0, 0, 0, 0));
    pending_numbers.push_back(make_number(64'd0, SIZE_64, 0, 0, 0, 0, 1, 0));
    pending_numbers.push_back(make_number(64'd0, SIZE_8, 0, 0, 0, 0, 0, 1));
    pending_numbers.push_back(make_number(64'd0, SIZE_16, 0, 0, 0, 0, 1, 1));
    pending_numbers.push_back(make_number(64'd0, SIZE_32, 0, 3, 0, 0, 0, 0));
    // zero padding after the sign; ignored with left-justify or precision
    pending_numbers.push_back(make_number(64'd42, SIZE_8, 6, 0, 0, 1, 1, 0));
    pending_numbers.push_back(make_number(-64'sd42, SIZE_16, 8, 0, 0, 1, 0, 0));
    pending_numbers.push_back(make_number(-64'sd42, SIZE_16, 8, 0, 1, 1, 0, 0));
    pending_numbers.push_back(make_number(-64'sd42, SIZE_32, 8, 4, 0, 1, 0, 0));
    // size extremes, most negative of each size
    pending_numbers.push_back(make_number(64'd127, SIZE_8, 0, 0, 0, 0, 0, 0));
    pending_numbers.push_back(make_number(64'h80, SIZE_8, 63, 0, 1, 0, 0, 0));
    pending_numbers.push_back(make_number(64'd32767, SIZE_16, 0, 0, 0, 0, 1, 0));
    pending_numbers.push_back(make_number(64'h8000, SIZE_16, 0, 40, 0, 0, 0, 0));
    pending_numbers.push_back(make_number(64'd2147483647, SIZE_32, 0, 0, 0, 0, 0, 1));
    pending_numbers.push_back(make_number(64'h8000_0000, SIZE_32, 20, 0, 0, 1, 0, 0));
    pending_numbers.push_back(make_number(64'h7FFF_FFFF_FFFF_FFFF, SIZE_64, 63, 0,
                                          0, 1, 1, 0));
    pending_numbers.push_back(make_number(64'h8000_0000_0000_0000, SIZE_64, 63, 0,
                                          0, 0, 0, 0));
    // precision above the limit is clamped
    pending_numbers.push_back(make_number(64'h8000_0000_0000_0000, SIZE_64, 0, 63,
                                          0, 0, 0, 0));
    // upper bits dropped by truncation
    pending_numbers.push_back(make_number(64'h1FF, SIZE_8, 0, 0, 0, 0, 0, 0));
    pending_numbers.push_back(make_number(64'hDEAD_BEEF_1234_5680, SIZE_8, 5, 0,
                                          0, 0, 1, 0));
    // text longer than the field, empty field, single digit precision
    pending_numbers.push_back(make_number(64'd12345, SIZE_32, 2, 0, 0, 1, 0, 0));
    pending_numbers.push_back(make_number(64'd9, SIZE_32, 0, 1, 0, 0, 0, 0));
    pending_numbers.push_back(make_number(64'd10, SIZE_64, 5, 0, 1, 0, 0, 1));
    // every option bit set at once
    pending_numbers.push_back(make_number('1, SIZE_64, 63, 63, 1, 1, 1, 1));

    repeat (RANDOM_COUNT) pending_numbers.push_back(random_number());

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while ((pending_numbers.size() != 0 || in_valid || expected_chars.size() != 0) &&
           cycle_count < CYCLE_LIMIT)
      @(posedge clk);
    timed_out = (cycle_count >= CYCLE_LIMIT);

    if (!timed_out) begin
      // let any stray output show up before the final verdict
      repeat (TAIL_CYCLES) @(posedge clk);
      if (expected_chars.size() != 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0d expected chars never arrived", expected_chars.size());
      end
    end

    if (timed_out)
      $display("signed_decimal_formatter_tb: done, errors");
    else if (mismatches == 0)
      $display("signed_decimal_formatter_tb: done, clean");
    else
      $display("signed_decimal_formatter_tb: done, errors");
    $finish;
  end

endmodule
